FILE: src/swtq_pkg.sv
// shared constants and codes for the sorted wake-up timer queue
`default_nettype none

package swtq_pkg;

    // default sizes of the queue and the tick counter
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TICK_WIDTH  = 48;

    // fixed field widths
    localparam int ID_W       = 8;
    localparam int DUR_W      = 32;
    localparam int TICK_OUT_W = 48;
    localparam int STATUS_W   = 2;
    localparam int EXT_W      = 64;

    // stream word widths
    localparam int IN_TDATA_W  = ID_W + DUR_W;
    localparam int OUT_TDATA_W = ID_W + TICK_OUT_W;

    // at most this many wake-ups per tick
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // request kinds
    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_WOKEN    = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

endpackage

`default_nettype wire

FILE: src/swtq_store.sv
// circular sleeper store: wake-time and id memory addressed relative to the queue head
`default_nettype none

module swtq_store #(
    parameter int QUEUE_DEPTH = swtq_pkg::DEF_QUEUE_DEPTH,
    parameter int TICK_WIDTH  = swtq_pkg::DEF_TICK_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_pop,
    input  logic                                 i_rd_en,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     i_rd_idx,
    output logic [TICK_WIDTH-1:0]                o_rd_wake,
    output logic [swtq_pkg::ID_W-1:0]            o_rd_id,
    input  logic                                 i_wr_en,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     i_wr_idx,
    input  logic [TICK_WIDTH-1:0]                i_wr_wake,
    input  logic [swtq_pkg::ID_W-1:0]            i_wr_id
);
    import swtq_pkg::*;

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W  = ADDR_W + 1;

    logic [TICK_WIDTH-1:0] r_wake_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]       r_id_mem   [QUEUE_DEPTH];
    logic [ADDR_W-1:0]     r_head;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     head_next;

    // queue position to memory address, wrapping once past the end
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                               input logic [OCC_W-1:0] k);
        logic [PTR_W-1:0] s;
        s = PTR_W'(head) + PTR_W'(k);
        if (s >= PTR_W'(QUEUE_DEPTH)) begin
            s = s - PTR_W'(QUEUE_DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    assign rd_addr   = phys(r_head, i_rd_idx);
    assign wr_addr   = phys(r_head, i_wr_idx);
    assign head_next = phys(r_head, OCC_W'(1));

    // head pointer moves on each pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (i_pop) begin
            r_head <= head_next;
        end
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_wake_mem[wr_addr] <= i_wr_wake;
            r_id_mem[wr_addr]   <= i_wr_id;
        end
        if (i_rd_en) begin
            o_rd_wake <= r_wake_mem[rd_addr];
            o_rd_id   <= r_id_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/sorted_wakeup_timer_queue.sv
// top level of the sorted wake-up timer queue: tick counter, sequencer and result register
//
//   port group   dir  contents
//   i_s_*        in   request word: tuser = opcode, tdata = waiter_id, sleep_ticks
//   o_m_*        out  result word: tuser = status, tdata = woken_id, tick_now, tlast = last
//
// a rejected or ignored sleep goes straight to its result; an accepted sleep is placed by an
// insertion walk from the tail, which reads and compares each entry with a later wake time
// and moves it one place toward the tail. a tick walks from the head and wakes due entries
// until it meets an entry not yet due, the queue empties or MAX_RESULTS are woken. synchronous
// active-low reset empties the queue and clears the counter. the request side is ready only
// in idle; a stalled result side holds the sequencer until the result register frees up.
`default_nettype none

module sorted_wakeup_timer_queue #(
    parameter int QUEUE_DEPTH = swtq_pkg::DEF_QUEUE_DEPTH,
    parameter int TICK_WIDTH  = swtq_pkg::DEF_TICK_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [swtq_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // waiter_id[7:0], sleep_ticks[39:8]
    input  logic                                i_s_tuser,   // opcode[0]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [swtq_pkg::OUT_TDATA_W-1:0]    o_m_tdata,   // woken_id[7:0], tick_now[55:8]
    output logic [swtq_pkg::STATUS_W-1:0]       o_m_tuser,   // status[1:0]
    output logic                                o_m_tlast
);
    import swtq_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = ((TICK_WIDTH > DUR_W) ? TICK_WIDTH : DUR_W) + 1;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_RD,
        S_INS_CMP,
        S_INS_NEW,
        S_EMIT,
        S_TICK_RD,
        S_TICK_CMP,
        S_FLUSH
    } t_state;

    t_state                r_state;
    logic [TICK_WIDTH-1:0] r_tick;
    logic [OCC_W-1:0]      r_occ;
    logic [OCC_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_cnt;
    logic [ID_W-1:0]       r_id;
    logic [DUR_W-1:0]      r_raw;
    logic [TICK_WIDTH-1:0] r_wake;
    t_status               r_status;
    logic                  r_pend;
    logic [ID_W-1:0]       r_pend_id;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [ID_W-1:0]       r_out_id;
    logic [TICK_OUT_W-1:0] r_out_tick;
    logic                  r_out_last;

    logic                  out_free;
    logic                  out_load;
    logic [SUM_W-1:0]      wake_sum;
    logic [TICK_WIDTH-1:0] wake_sat;
    logic [EXT_W-1:0]      tick_ext;
    logic [TICK_WIDTH-1:0] cmp_ref;
    logic                  cmp_le;
    logic                  pop;
    logic                  rd_en;
    logic [OCC_W-1:0]      rd_idx;
    logic                  wr_en;
    logic [TICK_WIDTH-1:0] wr_wake;
    logic [ID_W-1:0]       wr_id;
    logic [TICK_WIDTH-1:0] rd_wake;
    logic [ID_W-1:0]       rd_id;

    assign out_free = !r_out_valid || i_m_tready;

    // wake time = now + duration, saturating at the counter maximum
    assign wake_sum = SUM_W'(r_tick) + SUM_W'(r_raw[DUR_W-2:0]);
    assign wake_sat = (wake_sum > SUM_W'(TICK_MAX)) ? TICK_MAX : wake_sum[TICK_WIDTH-1:0];

    assign tick_ext = EXT_W'(r_tick);

    // shared comparator: queued wake time against the counter or the new wake time
    assign cmp_ref = (r_state == S_TICK_CMP) ? r_tick : r_wake;
    assign cmp_le  = (rd_wake <= cmp_ref);

    assign pop = (r_state == S_TICK_CMP) && cmp_le && (!r_pend || out_free);

    // result register takes a new word this cycle
    assign out_load = out_free && ((r_state == S_EMIT) || (r_state == S_FLUSH) ||
                                   (pop && r_pend));

    // store access control
    always_comb begin
        rd_en   = 1'b0;
        rd_idx  = '0;
        wr_en   = 1'b0;
        wr_wake = r_wake;
        wr_id   = r_id;
        if (r_state == S_INS_RD && r_pos != '0) begin
            rd_en  = 1'b1;
            rd_idx = OCC_W'(r_pos - 1'b1);
        end
        if (r_state == S_TICK_RD) begin
            rd_en = 1'b1;
        end
        if (r_state == S_INS_CMP && !cmp_le) begin
            wr_en   = 1'b1;
            wr_wake = rd_wake;
            wr_id   = rd_id;
        end
        if (r_state == S_INS_NEW) begin
            wr_en = 1'b1;
        end
    end

    swtq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pop     (pop),
        .i_rd_en   (rd_en),
        .i_rd_idx  (rd_idx),
        .o_rd_wake (rd_wake),
        .o_rd_id   (rd_id),
        .i_wr_en   (wr_en),
        .i_wr_idx  (r_pos),
        .i_wr_wake (wr_wake),
        .i_wr_id   (wr_id)
    );

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_occ       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_id  <= i_s_tdata[ID_W-1:0];
                        r_raw <= i_s_tdata[ID_W +: DUR_W];
                        if (t_op'(i_s_tuser) == OP_TICK) begin
                            if (r_tick != TICK_MAX) begin
                                r_tick <= r_tick + 1'b1;
                            end
                            r_cnt   <= '0;
                            r_pend  <= 1'b0;
                            r_state <= S_TICK_RD;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_raw == '0 || r_raw[DUR_W-1]) begin
                        r_status <= ST_IGNORED;
                        r_state  <= S_EMIT;
                    end else if (r_occ == OCC_W'(QUEUE_DEPTH)) begin
                        r_status <= ST_FULL;
                        r_state  <= S_EMIT;
                    end else begin
                        r_wake  <= wake_sat;
                        r_pos   <= r_occ;
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_RD: begin
                    r_state <= (r_pos == '0) ? S_INS_NEW : S_INS_CMP;
                end
                S_INS_CMP: begin
                    // later entries move one place toward the tail
                    if (cmp_le) begin
                        r_state <= S_INS_NEW;
                    end else begin
                        r_pos   <= OCC_W'(r_pos - 1'b1);
                        r_state <= S_INS_RD;
                    end
                end
                S_INS_NEW: begin
                    r_occ    <= OCC_W'(r_occ + 1'b1);
                    r_status <= ST_ACCEPTED;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_id     <= r_id;
                        r_out_tick   <= tick_ext[TICK_OUT_W-1:0];
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_TICK_RD: begin
                    if (r_occ == '0 || r_cnt == CNT_W'(MAX_RESULTS)) begin
                        r_state <= r_pend ? S_FLUSH : S_IDLE;
                    end else begin
                        r_state <= S_TICK_CMP;
                    end
                end
                S_TICK_CMP: begin
                    // a due head entry is held back until the next one is known
                    if (!cmp_le) begin
                        r_state <= r_pend ? S_FLUSH : S_IDLE;
                    end else if (!r_pend || out_free) begin
                        if (r_pend) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_WOKEN;
                            r_out_id     <= r_pend_id;
                            r_out_tick   <= tick_ext[TICK_OUT_W-1:0];
                            r_out_last   <= 1'b0;
                        end
                        r_pend    <= 1'b1;
                        r_pend_id <= rd_id;
                        r_occ     <= OCC_W'(r_occ - 1'b1);
                        r_cnt     <= CNT_W'(r_cnt + 1'b1);
                        r_state   <= S_TICK_RD;
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= ST_WOKEN;
                        r_out_id     <= r_pend_id;
                        r_out_tick   <= tick_ext[TICK_OUT_W-1:0];
                        r_out_last   <= 1'b1;
                        r_pend       <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_tick, r_out_id};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire
